FILE: src/stereo_pan_ramp_top_defines.svh
// Assertion helpers used by the stereo pan ramp datapath.
`ifndef STEREO_PAN_RAMP_TOP_DEFINES_SVH
`define STEREO_PAN_RAMP_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/spr_pkg.sv
package spr_pkg;

    localparam int STEP_W = 3;
    typedef logic [STEP_W-1:0] step_t;

    // quotient bits of the run-start divide: (17-bit span) << 16
    localparam int QUO_W = 33;
    localparam int CNT_W = 6;

    typedef enum logic [2:0] {
        OP_WAIT_IN,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_STEP_LOAD,
        OP_ROM_L,
        OP_MUL_L,
        OP_MUL_R,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        C_NEXT,
        C_NO_ITEM,
        C_NO_DIV,
        C_DIV_MORE,
        C_OUT_BUSY
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    typedef struct packed {
        logic no_item;
        logic no_div;
        logic div_more;
        logic out_busy;
    } stat_t;

    // effective configuration: pans clamped to 65536, frame count at least one
    typedef struct packed {
        logic [16:0] pan_start;
        logic [16:0] pan_end;
        logic [15:0] frame_count;
    } cfg_t;

    // Left gain for pan k / 2^bits, unsigned Q1.16, rounded to nearest.
    function automatic logic [16:0] gain_entry(int unsigned k, int unsigned bits);
        logic [63:0] full;
        logic [63:0] kk;
        logic [63:0] n;
        logic [63:0] s;
        logic [63:0] rhs;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] t;
        full = 64'(1) << bits;
        kk   = 64'(k);
        n    = full - kk;
        s    = kk * kk + n * n;
        rhs  = (kk * kk) << 34;
        lo   = 64'd0;
        hi   = 64'd65536;
        if (k == 0) begin
            return 17'd0;
        end
        while (lo < hi) begin
            mid = (lo + hi + 64'd1) >> 1;
            t   = 64'd2 * mid - 64'd1;
            if (t * t * s <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 64'd1;
            end
        end
        return lo[16:0];
    endfunction

endpackage

FILE: src/spr_gain_rom.sv
module spr_gain_rom #(
    parameter int GAIN_ROM_BITS = 10
) (
    input  logic                     aclk,
    input  logic [GAIN_ROM_BITS:0]   addr,
    output logic [16:0]              q
);

    localparam int DEPTH = (1 << GAIN_ROM_BITS) + 1;

    typedef logic [16:0] entry_t;
    typedef entry_t rom_arr_t [DEPTH];

    function automatic rom_arr_t build_rom();
        rom_arr_t r;
        for (int k = 0; k < DEPTH; k++) begin
            r[k] = spr_pkg::gain_entry(k, GAIN_ROM_BITS);
        end
        return r;
    endfunction

    localparam rom_arr_t GAIN_TABLE = build_rom();

    logic [16:0] q_reg;

    always_ff @(posedge aclk) begin
        q_reg <= GAIN_TABLE[addr];
    end

    assign q = q_reg;

endmodule

FILE: src/spr_ucode.sv
module spr_ucode (
    input  logic            aclk,
    input  logic            aresetn,
    input  spr_pkg::stat_t  stat,
    output spr_pkg::op_t    op
);

    localparam spr_pkg::step_t S_WAIT  = spr_pkg::STEP_W'(0);
    localparam spr_pkg::step_t S_DIV   = spr_pkg::STEP_W'(2);
    localparam spr_pkg::step_t S_ROM_L = spr_pkg::STEP_W'(4);
    localparam spr_pkg::step_t S_EMIT  = spr_pkg::STEP_W'(7);
    localparam spr_pkg::step_t S_NONE  = spr_pkg::STEP_W'(0);

    // The step after the last one wraps to the wait step.
    localparam spr_pkg::uword_t PROGRAM [8] = '{
        '{op: spr_pkg::OP_WAIT_IN,   cond: spr_pkg::C_NO_ITEM,  target: S_WAIT},
        '{op: spr_pkg::OP_DIV_INIT,  cond: spr_pkg::C_NO_DIV,   target: S_ROM_L},
        '{op: spr_pkg::OP_DIV_STEP,  cond: spr_pkg::C_DIV_MORE, target: S_DIV},
        '{op: spr_pkg::OP_STEP_LOAD, cond: spr_pkg::C_NEXT,     target: S_NONE},
        '{op: spr_pkg::OP_ROM_L,     cond: spr_pkg::C_NEXT,     target: S_NONE},
        '{op: spr_pkg::OP_MUL_L,     cond: spr_pkg::C_NEXT,     target: S_NONE},
        '{op: spr_pkg::OP_MUL_R,     cond: spr_pkg::C_NEXT,     target: S_NONE},
        '{op: spr_pkg::OP_EMIT,      cond: spr_pkg::C_OUT_BUSY, target: S_EMIT}
    };

    spr_pkg::step_t  step_reg;
    spr_pkg::step_t  step_next;
    spr_pkg::uword_t word;
    logic            taken;

    assign word = PROGRAM[step_reg];

    always_comb begin
        case (word.cond)
            spr_pkg::C_NEXT:     taken = 1'b0;
            spr_pkg::C_NO_ITEM:  taken = stat.no_item;
            spr_pkg::C_NO_DIV:   taken = stat.no_div;
            spr_pkg::C_DIV_MORE: taken = stat.div_more;
            spr_pkg::C_OUT_BUSY: taken = stat.out_busy;
            default:             taken = 1'b0;
        endcase
        step_next = taken ? word.target : step_reg + spr_pkg::STEP_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_WAIT;
        end else begin
            step_reg <= step_next;
        end
    end

    assign op = word.op;

endmodule

FILE: src/spr_datapath.sv
`include "stereo_pan_ramp_top_defines.svh"

module spr_datapath #(
    parameter int GAIN_ROM_BITS = 10,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  spr_pkg::op_t                  op,
    output spr_pkg::stat_t                stat,
    input  spr_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic signed [SAMPLE_BITS-1:0] m_left,
    output logic signed [SAMPLE_BITS-1:0] m_right,
    output logic                          m_last,
    output logic [GAIN_ROM_BITS:0]        rom_addr,
    input  logic [16:0]                   rom_q
);

    localparam int P_W = SAMPLE_BITS + 18;
    localparam int R_W = P_W - 16;
    localparam logic signed [P_W-1:0] HALF_LSB = P_W'(32768);
    localparam logic signed [R_W-1:0] SAT_MAX  = R_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [R_W-1:0] SAT_MIN  = R_W'(-(1 << (SAMPLE_BITS - 1)));
    localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;
    localparam logic [32:0] ROUND_HALF = 33'(1) << (31 - GAIN_ROM_BITS);
    localparam logic [GAIN_ROM_BITS:0] ROM_FULL = {1'b1, {GAIN_ROM_BITS{1'b0}}};
    localparam int QW = spr_pkg::QUO_W;
    localparam logic [spr_pkg::CNT_W-1:0] DIV_STEPS = spr_pkg::CNT_W'(QW);

    function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [P_W-1:0] p);
        logic signed [P_W-1:0] b;
        logic signed [R_W-1:0] r;
        b = p + HALF_LSB;
        r = b[P_W-1:16];
        if (r > SAT_MAX) begin
            r = SAT_MAX;
        end else if (r < SAT_MIN) begin
            r = SAT_MIN;
        end
        return r[SAMPLE_BITS-1:0];
    endfunction

    // control state
    logic [15:0]                   frames_done_reg;
    logic [33:0]                   pan_pos_reg;
    logic [33:0]                   pan_step_reg;
    logic                          m_tvalid_reg;

    // payload
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic                          start_reg;
    logic                          last_reg;
    logic                          neg_reg;
    logic [15:0]                   rem_reg;
    logic [QW-1:0]                 quo_reg;
    logic [spr_pkg::CNT_W-1:0]     cnt_reg;
    logic signed [P_W-1:0]         mul_reg;
    logic signed [SAMPLE_BITS-1:0] left_reg;
    logic signed [SAMPLE_BITS-1:0] m_left_reg;
    logic signed [SAMPLE_BITS-1:0] m_right_reg;
    logic                          m_last_reg;

    logic        accept;
    logic        emit;
    logic        multi;
    logic [15:0] divisor;
    logic [16:0] span;
    logic [16:0] trial;
    logic        q_bit;
    logic [15:0] rem_next;
    logic [33:0] quo_ext;
    logic [33:0] pos_raw;
    logic [32:0] pos_c;
    logic [32:0] pos_sum;
    logic [GAIN_ROM_BITS:0] idx;

    assign s_tready = (op == spr_pkg::OP_WAIT_IN);
    assign accept   = s_tready && s_tvalid;
    assign multi    = (cfg.frame_count > 16'd1);
    assign divisor  = cfg.frame_count - 16'd1;

    assign stat.no_item  = !s_tvalid;
    assign stat.no_div   = !(start_reg && multi);
    assign stat.div_more = (cnt_reg != spr_pkg::CNT_W'(1));
    assign stat.out_busy = m_tvalid_reg && !m_tready;

    assign emit = (op == spr_pkg::OP_EMIT) && !stat.out_busy;

    // restoring divide, one quotient bit a step
    always_comb begin
        span     = (cfg.pan_end >= cfg.pan_start) ? cfg.pan_end - cfg.pan_start
                                                  : cfg.pan_start - cfg.pan_end;
        trial    = {rem_reg, quo_reg[QW-1]};
        q_bit    = (trial >= {1'b0, divisor});
        rem_next = q_bit ? 16'(trial - {1'b0, divisor}) : trial[15:0];
        quo_ext  = {1'b0, quo_reg};
    end

    // gain table index from the current pan position
    always_comb begin
        pos_raw = (last_reg && multi) ? {1'b0, cfg.pan_end, 16'h0000} : pan_pos_reg;
        if (pos_raw[33]) begin
            pos_c = 33'd0;
        end else if (pos_raw[32:0] > ONE_Q32) begin
            pos_c = ONE_Q32;
        end else begin
            pos_c = pos_raw[32:0];
        end
        pos_sum  = pos_c + ROUND_HALF;
        idx      = pos_sum[32:32-GAIN_ROM_BITS];
        rom_addr = (op == spr_pkg::OP_MUL_L) ? ROM_FULL - idx : idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frames_done_reg <= 16'd0;
            pan_pos_reg     <= 34'd0;
            pan_step_reg    <= 34'd0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (accept && frames_done_reg == 16'd0) begin
                pan_pos_reg  <= {1'b0, cfg.pan_start, 16'h0000};
                pan_step_reg <= 34'd0;
            end
            if (op == spr_pkg::OP_STEP_LOAD) begin
                pan_step_reg <= neg_reg ? 34'd0 - quo_ext : quo_ext;
            end
            if (emit) begin
                frames_done_reg <= last_reg ? 16'd0 : frames_done_reg + 16'd1;
                pan_pos_reg     <= pan_pos_reg + pan_step_reg;
                m_tvalid_reg    <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
            start_reg  <= (frames_done_reg == 16'd0);
            last_reg   <= ({1'b0, frames_done_reg} + 17'd1) >= {1'b0, cfg.frame_count};
            neg_reg    <= (cfg.pan_end < cfg.pan_start);
        end
        case (op)
            spr_pkg::OP_DIV_INIT: begin
                rem_reg <= 16'd0;
                quo_reg <= {span, 16'h0000};
                cnt_reg <= DIV_STEPS;
            end
            spr_pkg::OP_DIV_STEP: begin
                rem_reg <= rem_next;
                quo_reg <= {quo_reg[QW-2:0], q_bit};
                cnt_reg <= cnt_reg - spr_pkg::CNT_W'(1);
            end
            spr_pkg::OP_MUL_L: begin
                mul_reg <= P_W'(sample_reg) * P_W'($signed({1'b0, rom_q}));
            end
            spr_pkg::OP_MUL_R: begin
                left_reg <= round_sat(mul_reg);
                mul_reg  <= P_W'(sample_reg) * P_W'($signed({1'b0, rom_q}));
            end
            default: begin
            end
        endcase
        if (emit) begin
            m_left_reg  <= left_reg;
            m_right_reg <= round_sat(mul_reg);
            m_last_reg  <= last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_left   = m_left_reg;
    assign m_right  = m_right_reg;
    assign m_last   = m_last_reg;

    `SPR_ASSERT_NOW(a_rem_below_divisor, aclk, aresetn, op == spr_pkg::OP_DIV_STEP,
                    rem_reg < divisor, "divide remainder reached the divisor")
    `SPR_ASSERT_NOW(a_step_in_range, aclk, aresetn, op == spr_pkg::OP_STEP_LOAD,
                    quo_reg <= ONE_Q32, "pan step quotient out of range")
    `SPR_ASSERT_NEXT(a_emit_valid, aclk, aresetn, emit, m_tvalid_reg,
                     "emitted frame not presented")
    `SPR_ASSERT_NEXT(a_run_restart, aclk, aresetn, emit && last_reg,
                     frames_done_reg == 16'd0, "frame counter not cleared after last frame")

endmodule

FILE: src/stereo_pan_ramp_top.sv
// Stereo pan ramp: one signed mono sample in, one stereo frame out, with the
// pan moving linearly from pan_start to pan_end over frame_count frames and
// the gains read from a normalised gain table. A small microprogram drives a
// shared datapath: an ordinary frame takes the sequencer through accept,
// run-start check, table read, two multiplies and emit, which writes the
// output register; the first frame of a run longer than one frame also runs
// the 33-step restoring divide that works out the per-frame pan step and
// loads that step before the table read. Emit waits while the output register
// holds a frame that has not been taken. The output register lets the next
// item be accepted while a frame waits to be taken. The gain table is a
// constant ROM with a registered read, so no clearing pass follows reset.
module stereo_pan_ramp_top #(
    parameter int GAIN_ROM_BITS = 10,
    parameter int SAMPLE_BITS   = 16,
    localparam int IN_W         = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int OUT_W        = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    // APB configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_W-1:0]     s_tdata,   // mono_sample
    // output stream
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // left_sample, right_sample
    output logic                m_tlast    // run_last
);

    localparam logic [1:0] REG_PAN_START   = 2'd0;
    localparam logic [1:0] REG_PAN_END     = 2'd1;
    localparam logic [1:0] REG_FRAME_COUNT = 2'd2;
    localparam logic [16:0] PAN_ONE = 17'd65536;

    logic [16:0] pan_start_reg;
    logic [16:0] pan_end_reg;
    logic [15:0] frame_count_reg;
    logic        wr_en;

    spr_pkg::cfg_t  cfg;
    spr_pkg::op_t   op;
    spr_pkg::stat_t stat;

    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic [GAIN_ROM_BITS:0]        rom_addr;
    logic [16:0]                   rom_q;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pan_start_reg   <= 17'd32768;
            pan_end_reg     <= 17'd32768;
            frame_count_reg <= 16'd1;
        end else if (wr_en) begin
            case (paddr[3:2])
                REG_PAN_START:   pan_start_reg   <= pwdata[16:0];
                REG_PAN_END:     pan_end_reg     <= pwdata[16:0];
                REG_FRAME_COUNT: frame_count_reg <= pwdata[15:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_PAN_START:   prdata = {15'd0, pan_start_reg};
            REG_PAN_END:     prdata = {15'd0, pan_end_reg};
            REG_FRAME_COUNT: prdata = {16'd0, frame_count_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // clamp pans to fully left, treat a zero frame count as one
    always_comb begin
        cfg.pan_start   = (pan_start_reg > PAN_ONE) ? PAN_ONE : pan_start_reg;
        cfg.pan_end     = (pan_end_reg > PAN_ONE) ? PAN_ONE : pan_end_reg;
        cfg.frame_count = (frame_count_reg == 16'd0) ? 16'd1 : frame_count_reg;
    end

    spr_ucode u_ucode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .stat    (stat),
        .op      (op)
    );

    spr_gain_rom #(
        .GAIN_ROM_BITS (GAIN_ROM_BITS)
    ) u_gain_rom (
        .aclk (aclk),
        .addr (rom_addr),
        .q    (rom_q)
    );

    spr_datapath #(
        .GAIN_ROM_BITS (GAIN_ROM_BITS),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .stat     (stat),
        .cfg      (cfg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_sample (s_tdata[SAMPLE_BITS-1:0]),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_left   (left),
        .m_right  (right),
        .m_last   (m_tlast),
        .rom_addr (rom_addr),
        .rom_q    (rom_q)
    );

    assign m_tdata = OUT_W'({right, left});

endmodule

FILE: bench/tb_stereo_pan_ramp_top.sv
`timescale 1ns / 100ps

module tb_stereo_pan_ramp_top;

    localparam int REG_PAN_START  = 0;
    localparam int REG_PAN_END    = 1;
    localparam int REG_FRAMES     = 2;

    localparam int GAIN_BITS      = 10;
    localparam int TAB_FULL       = 1 << GAIN_BITS;
    localparam int ROUND_SHIFT    = 31 - GAIN_BITS;
    localparam int INDEX_SHIFT    = 32 - GAIN_BITS;
    localparam int PAN_FULL       = 65536;

    localparam int TOTAL_ITEMS    = 1550;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 60;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] right;
        logic        last;
    } pan_frame_t;

    // Mirrors the panner: register copies, ramp state and the normalised gain table.
    class pan_scoreboard;
        logic [16:0]  gain_tab[0:TAB_FULL];
        logic [16:0]  reg_start;
        logic [16:0]  reg_end;
        logic [15:0]  reg_frames;
        logic [33:0]  pos_acc;
        logic [33:0]  step_acc;
        logic [15:0]  done_cnt;
        pan_frame_t   pending[$];
        int unsigned  errors;

        function new();
            longint unsigned s;
            longint unsigned rhs;
            longint unsigned t;
            int unsigned     g;
            int unsigned     trial;
            for (int k = 0; k <= TAB_FULL; k++) begin
                s   = longint'(k) * k + longint'(TAB_FULL - k) * (TAB_FULL - k);
                rhs = (longint'(k) * k) << 34;
                g   = 0;
                // build the largest g with (2g-1)^2 * s <= k^2 * 2^34, bit by bit
                for (int b = 16; b >= 0; b--) begin
                    trial = g | (1 << b);
                    t     = 2 * longint'(trial) - 1;
                    if (trial <= PAN_FULL && t * t * s <= rhs) begin
                        g = trial;
                    end
                end
                gain_tab[k] = g[16:0];
            end
            reg_start  = 17'd32768;
            reg_end    = 17'd32768;
            reg_frames = 16'd1;
            pos_acc    = '0;
            step_acc   = '0;
            done_cnt   = '0;
            errors     = 0;
        endfunction

        function void set_reg(int idx, logic [31:0] val);
            case (idx)
                REG_PAN_START: reg_start  = val[16:0];
                REG_PAN_END:   reg_end    = val[16:0];
                REG_FRAMES:    reg_frames = val[15:0];
                default: ;
            endcase
        endfunction

        function logic [15:0] scale_gain(logic signed [15:0] smp, logic [16:0] g);
            longint r;
            r = (longint'(smp) * longint'(g) + 32768) >>> 16;
            if (r > 32767) r = 32767;
            if (r < -32768) r = -32768;
            return r[15:0];
        endfunction

        function void note_input(logic signed [15:0] smp);
            logic [16:0] ps;
            logic [16:0] pe;
            logic [15:0] fc;
            logic [33:0] mag;
            logic [33:0] quo;
            logic [33:0] pos;
            logic [10:0] idx;
            logic        last_frame;
            pan_frame_t  f;
            fc = (reg_frames == 0) ? 16'd1 : reg_frames;
            ps = (reg_start > PAN_FULL) ? 17'(PAN_FULL) : reg_start;
            pe = (reg_end > PAN_FULL) ? 17'(PAN_FULL) : reg_end;
            // load the ramp at the first frame of a run
            if (done_cnt == 0) begin
                pos_acc = 34'(ps) << 16;
                if (fc > 1) begin
                    mag = (pe >= ps) ? (34'(pe - ps) << 16) : (34'(ps - pe) << 16);
                    quo = mag / 34'(fc - 16'd1);
                    step_acc = (pe >= ps) ? quo : -quo;
                end else begin
                    step_acc = '0;
                end
            end
            last_frame = (32'(done_cnt) + 1) >= 32'(fc);
            pos = (last_frame && fc > 1) ? (34'(pe) << 16) : pos_acc;
            if (pos[33]) begin
                pos = '0;
            end else if (pos > (34'd1 << 32)) begin
                pos = 34'd1 << 32;
            end
            idx = 11'((pos + (34'd1 << ROUND_SHIFT)) >> INDEX_SHIFT);
            f.left  = scale_gain(smp, gain_tab[idx]);
            f.right = scale_gain(smp, gain_tab[TAB_FULL - idx]);
            f.last  = last_frame;
            pending.push_back(f);
            done_cnt = last_frame ? 16'd0 : done_cnt + 16'd1;
            pos_acc  = pos_acc + step_acc;
        endfunction

        function void report(string what, longint want, longint got);
            errors++;
            if (errors <= REPORT_LIMIT) begin
                $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
            end
        endfunction

        function void check_frame(logic [31:0] data, logic last);
            pan_frame_t want;
            if (pending.size() == 0) begin
                report("frame with none outstanding", 0, data);
                return;
            end
            want = pending.pop_front();
            if (data[15:0] !== want.left) begin
                report("wrong left sample", $signed(want.left), $signed(data[15:0]));
            end
            if (data[31:16] !== want.right) begin
                report("wrong right sample", $signed(want.right), $signed(data[31:16]));
            end
            if (last !== want.last) begin
                report("wrong run_last", want.last, last);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // mono_sample
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;   // left_sample, right_sample
    logic        m_tlast;   // run_last

    pan_scoreboard board;
    int unsigned   items_sent;
    int unsigned   idle_cycles;
    int            sink_mode;
    bit            hold_req;

    stereo_pan_ramp_top DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 15))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'hffff;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] pick_pan();
        case ($urandom_range(0, 9))
            0: return 32'd0;
            1: return 32'(PAN_FULL);
            2: return $urandom_range(PAN_FULL + 1, 131071);
            3: return 32'd32768;
            default: return $urandom_range(0, PAN_FULL);
        endcase
    endfunction

    function automatic logic [31:0] pick_frames();
        case ($urandom_range(0, 15))
            0: return 32'd0;
            1: return 32'd65535;
            2: return 32'd1;
            3, 4: return $urandom_range(2, 64);
            default: return $urandom_range(1, 8);
        endcase
    endfunction

    task automatic write_reg(input int idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx * 4);
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, val);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic push_sample(input logic [15:0] smp);
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        do @(posedge aclk); while (!s_tready);
        board.note_input(smp);
        items_sent++;
    endtask

    // Lower valid and wait until every outstanding frame has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (board.pending.size() != 0) @(posedge aclk);
    endtask

    task automatic send_batch(input int n, input bit gaps);
        int burst;
        burst = $urandom_range(1, 20);
        for (int i = 0; i < n; i++) begin
            push_sample(pick_sample());
            burst--;
            if (gaps && burst == 0) begin
                s_tvalid <= 1'b0;
                if ($urandom_range(0, 4) == 0) begin
                    repeat ($urandom_range(13, 60)) @(posedge aclk);
                end else begin
                    repeat ($urandom_range(1, 12)) @(posedge aclk);
                end
                burst = $urandom_range(1, 20);
            end
        end
    endtask

    // Result side: ready pattern per phase, with one long hold-off on request.
    initial begin
        int unsigned tick;
        tick = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            tick++;
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            case (sink_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= ($urandom_range(0, 3) != 0);
                2: m_tready <= ((tick % 11) < 6);
                default: m_tready <= 1'($urandom_range(0, 1));
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            board.check_frame(m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        int batch;
        bit held;
        board       = new();
        items_sent  = 0;
        idle_cycles = 0;
        sink_mode   = 0;
        hold_req    = 1'b0;
        held        = 1'b0;
        aresetn  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // centred fixed pan straight after reset, sample extremes
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hffff);
        drain();

        // run stretched after it started: position sweeps below zero
        write_reg(REG_PAN_START, PAN_FULL);
        write_reg(REG_PAN_END, 0);
        write_reg(REG_FRAMES, 2);
        push_sample(16'h7fff);
        drain();
        write_reg(REG_FRAMES, 5);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h4000);
        push_sample(16'hc000);
        drain();

        // stretched rising run: position passes fully left
        write_reg(REG_PAN_START, 32768);
        write_reg(REG_PAN_END, PAN_FULL);
        write_reg(REG_FRAMES, 2);
        push_sample(16'h7fff);
        drain();
        write_reg(REG_FRAMES, 4);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        drain();

        // pans beyond fully left clamp, zero frame count acts as one
        write_reg(REG_PAN_START, 131071);
        write_reg(REG_PAN_END, 131071);
        write_reg(REG_FRAMES, 0);
        push_sample(16'h7fff);
        push_sample(16'h8001);
        drain();

        // long run cut short by a frame count of one mid-run
        write_reg(REG_PAN_START, 0);
        write_reg(REG_PAN_END, PAN_FULL);
        write_reg(REG_FRAMES, 65535);
        push_sample(16'h7fff);
        push_sample(16'h1234);
        push_sample(16'h8000);
        drain();
        write_reg(REG_PAN_END, 0);
        write_reg(REG_FRAMES, 1);
        push_sample(16'h7fff);
        drain();

        // descending ramp with a step smaller than one pan unit
        write_reg(REG_PAN_START, 1);
        write_reg(REG_PAN_END, 0);
        write_reg(REG_FRAMES, 3);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h5555);
        drain();

        while (items_sent < TOTAL_ITEMS) begin
            if ($urandom_range(0, 2) != 0) write_reg(REG_PAN_START, pick_pan());
            if ($urandom_range(0, 2) != 0) write_reg(REG_PAN_END, pick_pan());
            if ($urandom_range(0, 2) != 0) write_reg(REG_FRAMES, pick_frames());
            sink_mode = $urandom_range(0, 3);
            if (!held && items_sent > 600) begin
                // stall the output long enough for the block to back up
                sink_mode = 0;
                hold_req  = 1'b1;
                held      = 1'b1;
                send_batch(30, 1'b0);
            end else begin
                batch = $urandom_range(5, 40);
                send_batch(batch, $urandom_range(0, 3) != 0);
            end
            drain();
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/spr_pkg.sv
src/spr_gain_rom.sv
src/spr_ucode.sv
src/spr_datapath.sv
src/stereo_pan_ramp_top.sv
bench/tb_stereo_pan_ramp_top.sv
